/* hdl/bifd_pkg.sv */
package bifd_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned VB_W      = 3;
    localparam int unsigned CFG_W     = 17;
    localparam int unsigned COUNT_W   = 17;
    localparam int unsigned OFFSET_W  = 16;
    localparam int unsigned END_W     = 20;
    localparam int unsigned WIN_DEPTH = 3;

    localparam logic [WORD_W-1:0] MB1_MAGIC      = 32'h1BAD_B002;
    localparam logic [WORD_W-1:0] MB2_MAGIC      = 32'hE852_50D6;
    localparam logic [WORD_W-1:0] ELF_MAGIC_WORD = 32'h464C_457F;

    localparam logic [CFG_W-1:0] MB1_RESET_WINDOW = 17'd8192;
    localparam logic [CFG_W-1:0] MB2_RESET_WINDOW = 17'd32768;
    localparam logic [CFG_W-1:0] WINDOW_CAP       = 17'd65536;

    // register indexes of the write port
    localparam logic CFG_MB1_SEARCH = 1'b0;
    localparam logic CFG_MB2_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        FMT_FLAT = 2'd0,
        FMT_ELF  = 2'd1,
        FMT_MB1  = 2'd2,
        FMT_MB2  = 2'd3
    } fmt_t;

    // one stage of the word window: the word and the sum of it and all newer words
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] sum;
    } win_cell_t;

    // a search window above the cap is taken as the cap
    function automatic logic [CFG_W-1:0] capped(input logic [CFG_W-1:0] lim);
        capped = (lim > WINDOW_CAP) ? WINDOW_CAP : lim;
    endfunction

endpackage

/* hdl/bifd_in_if.sv */
interface bifd_in_if;
    logic                              valid;
    logic                              ready;
    logic [bifd_pkg::WORD_W-1:0]       image_word;
    logic [bifd_pkg::VB_W-1:0]         valid_bytes;
    logic                              last_word;

    modport source (output valid, image_word, valid_bytes, last_word, input ready);
    modport sink   (input valid, image_word, valid_bytes, last_word, output ready);
endinterface

/* hdl/bifd_out_if.sv */
interface bifd_out_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        format_code;
    logic                              mb1_found;
    logic [bifd_pkg::OFFSET_W-1:0]     mb1_offset;
    logic                              mb2_found;
    logic [bifd_pkg::OFFSET_W-1:0]     mb2_offset;

    modport source (output valid, format_code, mb1_found, mb1_offset, mb2_found,
                    mb2_offset, input ready);
    modport sink   (input valid, format_code, mb1_found, mb1_offset, mb2_found,
                    mb2_offset, output ready);
endinterface

/* hdl/bifd_cell.sv */
module bifd_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        shift,
    input  logic                        clear,
    input  logic [bifd_pkg::WORD_W-1:0] new_word,
    input  bifd_pkg::win_cell_t         prev,
    output bifd_pkg::win_cell_t         stage
);

    bifd_pkg::win_cell_t cell_reg;
    bifd_pkg::win_cell_t cell_next;

    // on shift take the neighbour's word, extend its running sum by the incoming word; clear empties the cell
    always_comb
    begin
        cell_next = cell_reg;
        if (shift)
        begin
            if (clear)
            begin
                cell_next = '0;
            end
            else
            begin
                cell_next.word = prev.word;
                cell_next.sum  = new_word + prev.sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign stage = cell_reg;

endmodule

/* hdl/boot_image_format_detector_core.sv */
// boot image format detector: takes a kernel image one little-endian 32-bit word per
// request, checks the ELF magic at the start and searches for the first valid Multiboot 1
// header (4-byte aligned, inside mb1_lim_reg) and Multiboot 2 header (8-byte aligned,
// inside mb2_lim_reg); on the word flagged last it gives one result request with the
// format code, found flags and offsets, then starts over for the next image. a word is
// taken every cycle unless a last word waits for the result slot, and the result is
// registered in the cycle after the last word. the three-cell word window carries
// running sums so that each header checksum needs a single add per word. the result
// register lets the next image stream in while a result waits to be taken; only a last
// word waits for the result slot to free up. search windows above 65536 bytes act as 65536
module boot_image_format_detector_core (
    input  logic                         clk,
    input  logic                         rst_n,
    bifd_in_if.sink                      image_in,
    bifd_out_if.source                   result_out,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [bifd_pkg::CFG_W-1:0]   cfg_data
);

    localparam int unsigned WD = bifd_pkg::WIN_DEPTH;

    // configuration
    logic [bifd_pkg::CFG_W-1:0] mb1_lim_reg;
    logic [bifd_pkg::CFG_W-1:0] mb2_lim_reg;

    // per-image state
    logic [bifd_pkg::COUNT_W-1:0]  word_count_reg;
    logic [bifd_pkg::COUNT_W-1:0]  word_count_next;
    logic                          elf_seen_reg;
    logic                          elf_seen_next;
    logic                          mb1_hit_reg;
    logic                          mb1_hit_next;
    logic [bifd_pkg::OFFSET_W-1:0] mb1_off_reg;
    logic [bifd_pkg::OFFSET_W-1:0] mb1_off_next;
    logic                          mb2_hit_reg;
    logic                          mb2_hit_next;
    logic [bifd_pkg::OFFSET_W-1:0] mb2_off_reg;
    logic [bifd_pkg::OFFSET_W-1:0] mb2_off_next;

    // result register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    bifd_pkg::fmt_t                fmt_reg;
    bifd_pkg::fmt_t                fmt_next;
    logic                          res_mb1_reg;
    logic                          res_mb1_next;
    logic [bifd_pkg::OFFSET_W-1:0] res_mb1_off_reg;
    logic [bifd_pkg::OFFSET_W-1:0] res_mb1_off_next;
    logic                          res_mb2_reg;
    logic                          res_mb2_next;
    logic [bifd_pkg::OFFSET_W-1:0] res_mb2_off_reg;
    logic [bifd_pkg::OFFSET_W-1:0] res_mb2_off_next;

    logic                          in_acc;
    logic                          out_acc;
    logic                          last_acc;
    logic                          full;
    logic                          size_ok;
    logic [bifd_pkg::END_W-1:0]    end_bytes;
    logic [bifd_pkg::COUNT_W-1:0]  w_m2;
    logic [bifd_pkg::COUNT_W-1:0]  w_m3;
    logic                          mb1_match;
    logic                          mb2_match;

    bifd_pkg::win_cell_t           link [WD+1];

    assign out_acc  = out_valid_reg && result_out.ready;
    // inner words never touch the result register, so only a last word waits for it
    assign image_in.ready = !image_in.last_word || !out_valid_reg || result_out.ready;
    assign in_acc   = image_in.valid && image_in.ready;
    assign last_acc = in_acc && image_in.last_word;

    // word window: cell 0 holds the newest previous word and its own value as sum,
    // cell k holds the word k+1 back and the sum of the k+1 newest words
    assign link[0].word = image_in.image_word;
    assign link[0].sum  = '0;

    for (genvar k = 0; k < WD; k++)
    begin : g_win
        bifd_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (in_acc),
            .clear    (image_in.last_word),
            .new_word (image_in.image_word),
            .prev     (link[k]),
            .stage    (link[k+1])
        );
    end

    // inner words are always full; a partial or empty last word counts its own bytes
    assign full      = !image_in.last_word || image_in.valid_bytes[2];
    assign end_bytes = {1'b0, word_count_reg, 2'b00} + bifd_pkg::END_W'(4);
    assign w_m2      = word_count_reg - bifd_pkg::COUNT_W'(2);
    assign w_m3      = word_count_reg - bifd_pkg::COUNT_W'(3);

    // header checks against the window: magic, checksum via running sum, window limit, mb2 alignment
    assign mb1_match = full && (word_count_reg >= bifd_pkg::COUNT_W'(2))
        && (end_bytes <= {3'b000, bifd_pkg::capped(mb1_lim_reg)})
        && (link[2].word == bifd_pkg::MB1_MAGIC)
        && ((link[2].sum + image_in.image_word) == '0);
    assign mb2_match = full && (word_count_reg >= bifd_pkg::COUNT_W'(3))
        && word_count_reg[0]
        && (end_bytes <= {3'b000, bifd_pkg::capped(mb2_lim_reg)})
        && (link[3].word == bifd_pkg::MB2_MAGIC)
        && ((link[3].sum + image_in.image_word) == '0);

    // image reaches 16 bytes: four words, or three plus a full last word
    assign size_ok = (word_count_reg >= bifd_pkg::COUNT_W'(4))
        || ((word_count_reg == bifd_pkg::COUNT_W'(3)) && full);

    always_comb
    begin
        elf_seen_next   = elf_seen_reg;
        mb1_hit_next    = mb1_hit_reg;
        mb1_off_next    = mb1_off_reg;
        mb2_hit_next    = mb2_hit_reg;
        mb2_off_next    = mb2_off_reg;
        word_count_next = word_count_reg;

        if ((word_count_reg == '0) && full && (image_in.image_word == bifd_pkg::ELF_MAGIC_WORD))
        begin
            elf_seen_next = 1'b1;
        end
        // only the lowest offset is kept
        if (!mb1_hit_reg && mb1_match)
        begin
            mb1_hit_next = 1'b1;
            mb1_off_next = {w_m2[bifd_pkg::OFFSET_W-3:0], 2'b00};
        end
        if (!mb2_hit_reg && mb2_match)
        begin
            mb2_hit_next = 1'b1;
            mb2_off_next = {w_m3[bifd_pkg::OFFSET_W-3:0], 2'b00};
        end
        if (word_count_reg != '1)
        begin
            word_count_next = word_count_reg + bifd_pkg::COUNT_W'(1);
        end

        // result from the updated flags, taken from this word too
        res_mb1_next     = mb1_hit_next;
        res_mb1_off_next = mb1_hit_next ? mb1_off_next : '0;
        res_mb2_next     = mb2_hit_next;
        res_mb2_off_next = mb2_hit_next ? mb2_off_next : '0;
        if (!(elf_seen_next && size_ok))
        begin
            fmt_next = bifd_pkg::FMT_FLAT;
        end
        else if (mb2_hit_next)
        begin
            fmt_next = bifd_pkg::FMT_MB2;
        end
        else if (mb1_hit_next)
        begin
            fmt_next = bifd_pkg::FMT_MB1;
        end
        else
        begin
            fmt_next = bifd_pkg::FMT_ELF;
        end

        // back to a clean image state once the last word is in
        if (image_in.last_word)
        begin
            elf_seen_next   = 1'b0;
            mb1_hit_next    = 1'b0;
            mb1_off_next    = '0;
            mb2_hit_next    = 1'b0;
            mb2_off_next    = '0;
            word_count_next = '0;
        end

        out_valid_next = out_valid_reg;
        if (out_acc)
        begin
            out_valid_next = 1'b0;
        end
        if (last_acc)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mb1_lim_reg    <= bifd_pkg::MB1_RESET_WINDOW;
            mb2_lim_reg    <= bifd_pkg::MB2_RESET_WINDOW;
            word_count_reg <= '0;
            elf_seen_reg   <= 1'b0;
            mb1_hit_reg    <= 1'b0;
            mb1_off_reg    <= '0;
            mb2_hit_reg    <= 1'b0;
            mb2_off_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    bifd_pkg::CFG_MB1_SEARCH: mb1_lim_reg <= cfg_data;
                    bifd_pkg::CFG_MB2_SEARCH: mb2_lim_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (in_acc)
            begin
                word_count_reg <= word_count_next;
                elf_seen_reg   <= elf_seen_next;
                mb1_hit_reg    <= mb1_hit_next;
                mb1_off_reg    <= mb1_off_next;
                mb2_hit_reg    <= mb2_hit_next;
                mb2_off_reg    <= mb2_off_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded with the last word
    always_ff @(posedge clk)
    begin
        if (last_acc)
        begin
            fmt_reg         <= fmt_next;
            res_mb1_reg     <= res_mb1_next;
            res_mb1_off_reg <= res_mb1_off_next;
            res_mb2_reg     <= res_mb2_next;
            res_mb2_off_reg <= res_mb2_off_next;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.format_code = fmt_reg;
    assign result_out.mb1_found   = res_mb1_reg;
    assign result_out.mb1_offset  = res_mb1_off_reg;
    assign result_out.mb2_found   = res_mb2_reg;
    assign result_out.mb2_offset  = res_mb2_off_reg;

    // a result only appears after a last word was taken
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(last_acc))
        else $error("result raised without a last word");

    // the image state is clean after the last word
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        last_acc |=> (word_count_reg == '0) && !elf_seen_reg && !mb1_hit_reg && !mb2_hit_reg)
        else $error("image state not cleared after last word");

    // a Multiboot 2 format needs a found Multiboot 2 header
    a_fmt_mb2_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (fmt_reg == bifd_pkg::FMT_MB2)) |-> res_mb2_reg)
        else $error("multiboot 2 format without header");

    // Multiboot 2 offsets are 8-byte aligned
    a_mb2_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        mb2_hit_reg |-> (mb2_off_reg[2:0] == 3'b000))
        else $error("multiboot 2 offset misaligned");

endmodule

/* tb/sv/boot_image_format_detector_core_test.sv */
module boot_image_format_detector_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    // one finished image as the detector should report it
    typedef struct packed {
        bifd_pkg::fmt_t fmt;
        logic           mb1_found;
        logic [15:0]    mb1_offset;
        logic           mb2_found;
        logic [15:0]    mb2_offset;
    } image_verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // configuration write port
    logic                       cfg_we;
    logic                       cfg_index;
    logic [bifd_pkg::CFG_W-1:0] cfg_data;

    bifd_in_if  image_ch ();
    bifd_out_if result_ch ();

    boot_image_format_detector_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .image_in   (image_ch),
        .result_out (result_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // detector model state: search windows plus the per-image scan state
    // ------------------------------------------------------------------
    logic [bifd_pkg::CFG_W-1:0]   mb1_window = bifd_pkg::MB1_RESET_WINDOW;
    logic [bifd_pkg::CFG_W-1:0]   mb2_window = bifd_pkg::MB2_RESET_WINDOW;
    logic [bifd_pkg::WORD_W-1:0]  recent [0:2];      // recent[0] is the newest earlier word
    logic [bifd_pkg::COUNT_W-1:0] words_seen;
    logic                         elf_seen;
    logic                         mb1_hit;
    logic [15:0]                  mb1_at;
    logic                         mb2_hit;
    logic [15:0]                  mb2_at;

    image_verdict_t verdicts_due [$];      // one entry per image still to be reported

    // stimulus bookkeeping
    logic [bifd_pkg::WORD_W-1:0] image_buf [$];
    bit  idling_on = 1'b1;
    bit  word_taken;
    int  stall_left;
    int  errors;
    int  words_sent;
    int  images_sent;
    int  results_checked;
    int  settings_used;

    function automatic void clear_image();
        recent[0]  = '0;
        recent[1]  = '0;
        recent[2]  = '0;
        words_seen = '0;
        elf_seen   = 1'b0;
        mb1_hit    = 1'b0;
        mb1_at     = '0;
        mb2_hit    = 1'b0;
        mb2_at     = '0;
    endfunction

    // search windows wider than 64 KiB behave as 64 KiB
    function automatic logic [19:0] window_limit(input logic [bifd_pkg::CFG_W-1:0] lim);
        return (lim > bifd_pkg::WINDOW_CAP) ? 20'(bifd_pkg::WINDOW_CAP) : 20'(lim);
    endfunction

    // advance the scan by one accepted word, queueing a verdict on the last one
    function automatic void scan_word(input logic [bifd_pkg::WORD_W-1:0] w,
                                      input logic [2:0] vb_in, input logic lst);
        logic [2:0]                  vb;
        logic                        full;
        logic [19:0]                 idx;
        logic [19:0]                 end_b;
        logic [19:0]                 image_bytes;
        logic [bifd_pkg::WORD_W-1:0] sum3;
        logic [bifd_pkg::WORD_W-1:0] sum4;
        image_verdict_t              v;
        // byte count only matters on the last word, and saturates at four
        vb    = (!lst || vb_in > 3'd4) ? 3'd4 : vb_in;
        full  = (vb == 3'd4);
        idx   = 20'(words_seen);
        end_b = (idx << 2) + 20'd4;
        sum3  = recent[1] + recent[0] + w;
        sum4  = recent[2] + sum3;

        if (idx == 20'd0 && full && w == bifd_pkg::ELF_MAGIC_WORD)
            elf_seen = 1'b1;
        // multiboot 1: three words, magic two words back, sum to zero
        if (!mb1_hit && full && idx >= 20'd2 && end_b <= window_limit(mb1_window) &&
            recent[1] == bifd_pkg::MB1_MAGIC && sum3 == '0)
        begin
            mb1_hit = 1'b1;
            mb1_at  = end_b[15:0] - 16'd12;
        end
        // multiboot 2: four words, 8-byte aligned, so it ends on an odd word
        if (!mb2_hit && full && idx >= 20'd3 && idx[0] && end_b <= window_limit(mb2_window) &&
            recent[2] == bifd_pkg::MB2_MAGIC && sum4 == '0)
        begin
            mb2_hit = 1'b1;
            mb2_at  = end_b[15:0] - 16'd16;
        end

        recent[2] = recent[1];
        recent[1] = recent[0];
        recent[0] = w;
        if (words_seen != {bifd_pkg::COUNT_W{1'b1}})
            words_seen = words_seen + 1'b1;

        if (lst)
        begin
            image_bytes = (idx << 2) + 20'(vb);
            if (!(elf_seen && image_bytes >= 20'd16))
                v.fmt = bifd_pkg::FMT_FLAT;
            else if (mb2_hit)
                v.fmt = bifd_pkg::FMT_MB2;
            else if (mb1_hit)
                v.fmt = bifd_pkg::FMT_MB1;
            else
                v.fmt = bifd_pkg::FMT_ELF;
            v.mb1_found  = mb1_hit;
            v.mb1_offset = mb1_hit ? mb1_at : 16'd0;
            v.mb2_found  = mb2_hit;
            v.mb2_offset = mb2_hit ? mb2_at : 16'd0;
            verdicts_due.push_back(v);
            clear_image();
        end
    endfunction

    task automatic note_error(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string field, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            note_error($sformatf("result %0d %s = %0h, expected %0h",
                                 results_checked, field, got, want));
    endtask

    // ------------------------------------------------------------------
    // handshakes are looked at mid-cycle, where every signal has settled;
    // the word is scored before any result so the order always holds
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : watch_requests
        image_verdict_t want;
        word_taken = rst_n && image_ch.valid && image_ch.ready;
        if (word_taken)
            scan_word(image_ch.image_word, image_ch.valid_bytes, image_ch.last_word);
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (verdicts_due.size() == 0)
                note_error("result request with no image outstanding");
            else
            begin
                want = verdicts_due.pop_front();
                check_field("format_code", 16'(result_ch.format_code), 16'(want.fmt));
                check_field("mb1_found", 16'(result_ch.mb1_found), 16'(want.mb1_found));
                check_field("mb1_offset", result_ch.mb1_offset, want.mb1_offset);
                check_field("mb2_found", 16'(result_ch.mb2_found), 16'(want.mb2_found));
                check_field("mb2_offset", result_ch.mb2_offset, want.mb2_offset);
            end
            results_checked++;
        end
    end

    // result side back-pressure: stalls come in random bursts while idling is on
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // present one word and hold it until the request is taken; valid stays high
    // on return so back-to-back words need no extra assignment
    task automatic send_word(input logic [bifd_pkg::WORD_W-1:0] w, input logic [2:0] vb,
                             input logic lst);
        int gap;
        gap = (idling_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        if (gap > 0)
        begin
            image_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        image_ch.valid       <= 1'b1;
        image_ch.image_word  <= w;
        image_ch.valid_bytes <= vb;
        image_ch.last_word   <= lst;
        do
            @(posedge clk);
        while (!word_taken);
        words_sent++;
    endtask

    // stream image_buf; inner words carry random byte counts, which must be ignored
    task automatic send_image(input logic [2:0] last_vb);
        int n;
        n = image_buf.size();
        for (int i = 0; i < n; i++)
            send_word(image_buf[i], (i == n - 1) ? last_vb : 3'($urandom_range(0, 7)),
                      i == n - 1);
        images_sent++;
    endtask

    function automatic void new_image(input int n, input bit noise);
        image_buf.delete();
        for (int i = 0; i < n; i++)
            image_buf.push_back(noise ? bifd_pkg::WORD_W'($urandom) : '0);
    endfunction

    // multiboot 1 header at word index at; a bad one gets a skewed checksum
    function automatic void put_mb1(input int at, input bit good);
        logic [bifd_pkg::WORD_W-1:0] flags;
        flags             = $urandom;
        image_buf[at]     = bifd_pkg::MB1_MAGIC;
        image_buf[at + 1] = flags;
        image_buf[at + 2] = -(bifd_pkg::MB1_MAGIC + flags) +
                            (good ? 0 : $urandom_range(1, 255));
    endfunction

    function automatic void put_mb2(input int at, input bit good);
        logic [bifd_pkg::WORD_W-1:0] arch;
        logic [bifd_pkg::WORD_W-1:0] hlen;
        arch              = $urandom_range(0, 1) ? 32'd0 : 32'd4;
        hlen              = 16 + 8 * $urandom_range(0, 8);
        image_buf[at]     = bifd_pkg::MB2_MAGIC;
        image_buf[at + 1] = arch;
        image_buf[at + 2] = hlen;
        image_buf[at + 3] = -(bifd_pkg::MB2_MAGIC + arch + hlen) +
                            (good ? 0 : $urandom_range(1, 255));
    endfunction

    // wait for every verdict, then let the result register go quiet
    task automatic wait_idle();
        image_ch.valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // only written between images, with the detector drained
    task automatic set_windows(input logic [bifd_pkg::CFG_W-1:0] mb1,
                               input logic [bifd_pkg::CFG_W-1:0] mb2);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= bifd_pkg::CFG_MB1_SEARCH;
        cfg_data  <= mb1;
        @(posedge clk);
        cfg_index <= bifd_pkg::CFG_MB2_SEARCH;
        cfg_data  <= mb2;
        @(posedge clk);
        cfg_we     <= 1'b0;
        mb1_window = mb1;
        mb2_window = mb2;
        settings_used++;
    endtask

    function automatic logic [bifd_pkg::CFG_W-1:0] pick_window();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return bifd_pkg::CFG_W'($urandom_range(10, 18));   // around the header sizes
            2:       return bifd_pkg::WINDOW_CAP;
            3:       return {bifd_pkg::CFG_W{1'b1}};
            4:       return bifd_pkg::CFG_W'($urandom);
            default: return bifd_pkg::CFG_W'($urandom_range(0, 260));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset windows: ELF size rule, both headers, odd byte counts on the last word
    task automatic test_basic_formats();
        // exactly sixteen bytes of ELF, then one byte short
        new_image(4, 1'b1);
        image_buf[0] = bifd_pkg::ELF_MAGIC_WORD;
        send_image(3'd4);
        send_image(3'd3);
        // a lone magic word, partial then full: too short either way
        new_image(1, 1'b0);
        image_buf[0] = bifd_pkg::ELF_MAGIC_WORD;
        send_image(3'd3);
        send_image(3'd4);
        // both headers present, multiboot 2 wins
        new_image(8, 1'b1);
        image_buf[0] = bifd_pkg::ELF_MAGIC_WORD;
        put_mb1(1, 1'b1);
        put_mb2(4, 1'b1);
        send_image(3'd4);
        // header finished by a partial word does not count; a count above four is full
        new_image(3, 1'b1);
        put_mb1(0, 1'b1);
        send_image(3'd3);
        send_image(3'd7);
        // misaligned multiboot 2, empty last word still leaves sixteen bytes
        new_image(5, 1'b1);
        image_buf[0] = bifd_pkg::ELF_MAGIC_WORD;
        put_mb2(1, 1'b1);
        send_image(3'd0);
    endtask

    // windows just below the header sizes, at them, and zero
    task automatic test_window_limits();
        for (int s = 0; s < 3; s++)
        begin
            case (s)
                0:       set_windows(bifd_pkg::CFG_W'(11), bifd_pkg::CFG_W'(15));
                1:       set_windows(bifd_pkg::CFG_W'(12), bifd_pkg::CFG_W'(16));
                default: set_windows('0, '0);
            endcase
            new_image(4, 1'b1);
            put_mb1(0, 1'b1);
            send_image(3'd4);
            new_image(4, 1'b1);
            put_mb2(0, 1'b1);
            send_image(3'd4);
        end
    endtask

    // mostly ELF-like images with random headers, good and broken, plus raw noise
    task automatic random_image();
        int n;
        int at;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : $urandom_range(6, 48);
        new_image(n, 1'b1);
        if ($urandom_range(0, 9) != 0)
        begin
            if ($urandom_range(0, 3) != 0)
                image_buf[0] = bifd_pkg::ELF_MAGIC_WORD;
            repeat ($urandom_range(0, 3))
            begin
                if ($urandom_range(0, 1) && n >= 3)
                    put_mb1($urandom_range(0, n - 3), $urandom_range(0, 3) != 0);
                else if (n >= 4)
                begin
                    at = $urandom_range(0, n - 4);
                    if ($urandom_range(0, 3) != 0)
                        at = at & ~1;
                    put_mb2(at, $urandom_range(0, 3) != 0);
                end
            end
        end
        send_image($urandom_range(0, 1) ? 3'd4 : 3'($urandom_range(0, 7)));
    endtask

    // several window settings; the last phase runs without any idling
    task automatic test_random_images();
        int start;
        for (int phase = 0; phase < 6; phase++)
        begin
            set_windows(pick_window(), pick_window());
            idling_on = (phase != 5);
            start = words_sent;
            while (words_sent - start < 310)
                random_image();
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        image_ch.valid       = 1'b0;
        image_ch.image_word  = '0;
        image_ch.valid_bytes = '0;
        image_ch.last_word   = 1'b0;
        result_ch.ready      = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = bifd_pkg::CFG_MB1_SEARCH;
        cfg_data             = '0;
        clear_image();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_formats();
        test_window_limits();
        test_random_images();
        wait_idle();

        $display("ran %0d images (%0d words) under %0d window settings",
                 images_sent, words_sent, settings_used);
        $display("checked %0d verdicts, %0d mismatches", results_checked, errors);
        if (errors == 0)
            $display("** boot_image_format_detector_core: PASSED **");
        else
            $display("** boot_image_format_detector_core: FAILED **");
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial
    begin
        #1_000_000;
        $display("watchdog expired with %0d verdicts outstanding", verdicts_due.size());
        $display("** boot_image_format_detector_core: FAILED **");
        $finish;
    end

endmodule
